// ===== hdl/kvs_pkg.sv =====
package kvs_pkg;

  localparam int MAX_KEYS = 64;
  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = AW + 1;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key_or_sample_time;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]  status;
  } out_item_t;

  // Selects what the datapath puts into the result register.
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_V0   = 2'd1;
  localparam logic [1:0] RES_BLND = 2'd2;

  typedef struct packed {
    logic          load_in;   // capture the input item
    logic          append;    // write key at count
    logic          clear;     // count goes to zero
    logic          rd_en;     // read memories at rd_addr
    logic [AW-1:0] rd_addr;
    logic          lat_t0;    // latch read data as left key
    logic          lat_t1;    // latch read data as right key
    logic          div_start;
    logic          div_step;
    logic          mul_start;
    logic          mul_step;
    logic          res_load;
    logic [1:0]    res_sel;
    logic [1:0]    res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [CW-1:0] count;
    logic          t_le_rd;   // t <= time just read
    logic          t0_le_t;   // left key time <= t
    logic          div_done;
    logic          mul_done;
  } sts_t;

endpackage

// ===== hdl/keyframe_vector_sampler.sv =====
// Keyframe linear interpolation of a 3-vector in Q16.16.
// Input channel (in_valid/in_stall/in_data): mode 0 appends a keyframe,
// mode 1 samples at a time, mode 2 clears the table. Every input transfer
// gives exactly one result transfer on out_valid/out_stall/out_data.
// Append, clear, the unused mode and the empty or full cases load the
// result in the decode state and raise out_valid from the output state.
// A sample walks the key table one key at a time over the single memory
// read port. When the first key answers, it gives the result; when no
// pair brackets the time, the last key is read and gives it. A bracket
// adds a 49-step restoring divider for the fraction and a 17-step
// shift-add multiplier.
// One item is in work at a time; a new item is taken the cycle after the
// result transfer. Reset clears the key count and the control state; the
// table contents are undefined until written. While the receiver stalls,
// the result stays in the output register and in_stall stays high.
module keyframe_vector_sampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kvs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kvs_pkg::out_item_t out_data
);

  kvs_pkg::cmd_t cmd;
  kvs_pkg::sts_t sts;

  kvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kvs_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .res     (out_data)
  );

endmodule

// ===== hdl/kvs_datapath.sv =====
module kvs_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  kvs_pkg::in_item_t   in_data,
  input  kvs_pkg::cmd_t       cmd,
  output kvs_pkg::sts_t       sts,
  output kvs_pkg::out_item_t  res
);

  logic [31:0] times_mem [kvs_pkg::MAX_KEYS];
  logic [95:0] vec_mem   [kvs_pkg::MAX_KEYS];
  logic [31:0] rd_t_r;
  logic [95:0] rd_v_r;
  kvs_pkg::in_item_t in_r;
  logic [kvs_pkg::CW-1:0] count_r;
  logic [31:0] t0_r;
  logic [95:0] v0_r;
  logic [95:0] v1_r;
  logic [31:0] span_r;
  logic [48:0] num_r;
  logic [32:0] rem_r;
  logic [16:0] frac_r;
  logic [5:0]  dcnt_r;
  logic [4:0]  mcnt_r;
  logic signed [49:0] acc_r [3];
  logic signed [32:0] dv_r  [3];
  logic [33:0] rem_try;
  kvs_pkg::out_item_t res_r;

  // Memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      times_mem[count_r[kvs_pkg::AW-1:0]] <= in_r.key_or_sample_time;
      vec_mem[count_r[kvs_pkg::AW-1:0]]   <= {in_r.in_x, in_r.in_y, in_r.in_z};
    end
    if (cmd.rd_en) begin
      rd_t_r <= times_mem[cmd.rd_addr];
      rd_v_r <= vec_mem[cmd.rd_addr];
    end
  end

  // Key count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Captured item and bracketing keys.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.lat_t0) begin
      t0_r <= rd_t_r;
      v0_r <= rd_v_r;
    end
    if (cmd.lat_t1) begin
      v1_r <= rd_v_r;
    end
  end

  // Restoring divider, one quotient bit per cycle over 49 bits.
  assign rem_try = {rem_r, num_r[48]} - {2'b00, span_r};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      span_r <= rd_t_r - t0_r;
      num_r  <= {1'b0, in_r.key_or_sample_time - t0_r, 16'd0};
      rem_r  <= '0;
      frac_r <= '0;
      dcnt_r <= 6'd49;
    end else if (cmd.div_step) begin
      num_r  <= {num_r[47:0], 1'b0};
      dcnt_r <= dcnt_r - 1'b1;
      if (span_r == 32'd0) begin
        frac_r <= '0;
      end else if (!rem_try[33]) begin
        rem_r  <= rem_try[32:0];
        frac_r <= {frac_r[15:0], 1'b1};
      end else begin
        rem_r  <= {rem_r[31:0], num_r[48]};
        frac_r <= {frac_r[15:0], 1'b0};
      end
    end
  end

  // Shift-and-add multiply of each difference by the 17-bit fraction.
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mcnt_r <= 5'd17;
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= '0;
        dv_r[k]  <= 33'(signed'(v1_r[95-32*k -: 32])) - 33'(signed'(v0_r[95-32*k -: 32]));
      end
    end else if (cmd.mul_step) begin
      mcnt_r <= mcnt_r - 1'b1;
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= (acc_r[k] <<< 1) +
                    (frac_r[mcnt_r - 1'b1] ? 50'(dv_r[k]) : 50'sd0);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.status <= cmd.res_status;
      case (cmd.res_sel)
        kvs_pkg::RES_V0: begin
          res_r.out_x <= v0_r[95:64];
          res_r.out_y <= v0_r[63:32];
          res_r.out_z <= v0_r[31:0];
        end
        kvs_pkg::RES_BLND: begin
          res_r.out_x <= v0_r[95:64] + acc_r[0][47:16];
          res_r.out_y <= v0_r[63:32] + acc_r[1][47:16];
          res_r.out_z <= v0_r[31:0]  + acc_r[2][47:16];
        end
        default: begin
          res_r.out_x <= '0;
          res_r.out_y <= '0;
          res_r.out_z <= '0;
        end
      endcase
    end
  end

  assign res = res_r;
  assign sts.mode     = in_r.mode;
  assign sts.count    = count_r;
  assign sts.t_le_rd  = in_r.key_or_sample_time <= rd_t_r;
  assign sts.t0_le_t  = t0_r <= in_r.key_or_sample_time;
  assign sts.div_done = dcnt_r == 6'd0;
  assign sts.mul_done = mcnt_r == 5'd0;

endmodule

// ===== hdl/kvs_ctrl.sv =====
module kvs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  kvs_pkg::sts_t sts,
  output kvs_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_CHK0  = 4'd3;
  localparam logic [3:0] S_RDN   = 4'd4;
  localparam logic [3:0] S_CHKN  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MUL0  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_LAST  = 4'd9;
  localparam logic [3:0] S_LASTV = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_BLND  = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [kvs_pkg::AW-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [kvs_pkg::CW-1:0] idx_ext;

  assign idx_ext = {1'b0, idx_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Accept when idle and the result register is free.
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;

  // Sequencer: decodes each item; a sample runs a linear search, then divide and multiply.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.res_sel    = kvs_pkg::RES_ZERO;
        cmd.res_status = kvs_pkg::ST_OK;
        case (sts.mode)
          kvs_pkg::MODE_APPEND: begin
            cmd.res_load = 1'b1;
            if (sts.count >= kvs_pkg::CW'(kvs_pkg::MAX_KEYS)) begin
              cmd.res_status = kvs_pkg::ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
            state_nxt = S_OUT;
          end
          kvs_pkg::MODE_SAMPLE: begin
            if (sts.count == '0) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = kvs_pkg::ST_EMPTY;
              state_nxt      = S_OUT;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = '0;
              idx_nxt     = '0;
              state_nxt   = S_RD0;
            end
          end
          kvs_pkg::MODE_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_load = 1'b1;
            state_nxt    = S_OUT;
          end
          default: begin
            cmd.res_load = 1'b1;
            state_nxt    = S_OUT;
          end
        endcase
      end
      S_RD0: begin
        cmd.lat_t0 = 1'b1;
        state_nxt  = S_CHK0;
      end
      S_CHK0: begin
        if (sts.count == kvs_pkg::CW'(1) || sts.t_le_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = kvs_pkg::RES_V0;
          state_nxt    = S_OUT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_r + 1'b1;
          state_nxt   = S_RDN;
        end
      end
      S_RDN: begin
        state_nxt = S_CHKN;
      end
      S_CHKN: begin
        // Right key is in the read register; left key in t0/v0.
        if (sts.t0_le_t && sts.t_le_rd) begin
          cmd.lat_t1    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (idx_ext + 1'b1 >= sts.count) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = kvs_pkg::AW'(sts.count - 1'b1);
          state_nxt   = S_LAST;
        end else begin
          cmd.lat_t0  = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_r + 2'd2;
          idx_nxt     = idx_r + 1'b1;
          state_nxt   = S_RDN;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_MUL0;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MUL0: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_BLND;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_BLND: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = kvs_pkg::RES_BLND;
        state_nxt    = S_OUT;
      end
      S_LAST: begin
        cmd.lat_t0 = 1'b1;
        state_nxt  = S_LASTV;
      end
      S_LASTV: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = kvs_pkg::RES_V0;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== test/keyframe_vector_sampler_tb.sv =====
`timescale 1ns / 100ps

module keyframe_vector_sampler_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1060;
  localparam logic [1:0] MODE_NONE = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  kvs_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  kvs_pkg::out_item_t out_data;

  keyframe_vector_sampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Shadow key table of the predictor.
  logic [31:0] key_time [kvs_pkg::MAX_KEYS];
  logic [31:0] key_vec  [kvs_pkg::MAX_KEYS][3];
  int          key_count;

  kvs_pkg::out_item_t expected_vectors[$];
  int                 error_count;
  int                 idle_pct;
  int                 quiet_cycles;

  // Blend one component between two keys with a Q1.16 fraction.
  function automatic logic [31:0] lerp_component(logic [31:0] a, logic [31:0] b,
                                                 logic [16:0] frac);
    longint va;
    longint vb;
    longint prod;
    longint q;
    va = longint'($signed(a));
    vb = longint'($signed(b));
    prod = (vb - va) * longint'({1'b0, frac});
    q = prod >>> 16;
    return 32'(va + q);
  endfunction

  // Predict the result of one item and update the shadow table.
  function automatic kvs_pkg::out_item_t predict_sample(kvs_pkg::in_item_t it);
    kvs_pkg::out_item_t r;
    logic [31:0] t;
    logic [31:0] span;
    logic [16:0] frac;
    logic [63:0] num;
    bit          found;
    r = '0;
    t = it.key_or_sample_time;
    found = 0;
    case (it.mode)
      kvs_pkg::MODE_APPEND: begin
        if (key_count >= kvs_pkg::MAX_KEYS) begin
          r.status = kvs_pkg::ST_FULL;
        end else begin
          key_time[key_count] = t;
          key_vec[key_count][0] = it.in_x;
          key_vec[key_count][1] = it.in_y;
          key_vec[key_count][2] = it.in_z;
          key_count++;
        end
      end
      kvs_pkg::MODE_SAMPLE: begin
        if (key_count == 0) begin
          r.status = kvs_pkg::ST_EMPTY;
        end else if (key_count == 1 || t <= key_time[0]) begin
          r.out_x = key_vec[0][0];
          r.out_y = key_vec[0][1];
          r.out_z = key_vec[0][2];
        end else begin
          for (int i = 0; i + 1 < key_count && !found; i++) begin
            if (key_time[i] <= t && t <= key_time[i+1]) begin
              span = key_time[i+1] - key_time[i];
              frac = '0;
              if (span != 0) begin
                num = {32'd0, t - key_time[i]} << 16;
                frac = 17'(num / {32'd0, span});
              end
              r.out_x = lerp_component(key_vec[i][0], key_vec[i+1][0], frac);
              r.out_y = lerp_component(key_vec[i][1], key_vec[i+1][1], frac);
              r.out_z = lerp_component(key_vec[i][2], key_vec[i+1][2], frac);
              found = 1;
            end
          end
          if (!found) begin
            r.out_x = key_vec[key_count-1][0];
            r.out_y = key_vec[key_count-1][1];
            r.out_z = key_vec[key_count-1][2];
          end
        end
      end
      kvs_pkg::MODE_CLEAR: key_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    kvs_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vectors.size() == 0) begin
        report_mismatch("unexpected transfer, x", out_data.out_x, 32'd0);
      end else begin
        want = expected_vectors.pop_front();
        if (out_data.out_x !== want.out_x) report_mismatch("x", out_data.out_x, want.out_x);
        if (out_data.out_y !== want.out_y) report_mismatch("y", out_data.out_y, want.out_y);
        if (out_data.out_z !== want.out_z) report_mismatch("z", out_data.out_z, want.out_z);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Present one item and hold it until the transfer. Valid drops only
  // while the sender idles, so back-to-back items keep it high.
  task automatic send_item(kvs_pkg::in_item_t it, bit has_golden,
                           kvs_pkg::out_item_t golden);
    kvs_pkg::out_item_t p;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_sample(it);
    if (has_golden) p = golden;
    expected_vectors.insert(expected_vectors.size(), p);
  endtask

  function automatic kvs_pkg::in_item_t make_item(logic [1:0] m, logic [31:0] t,
                                                  logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
    kvs_pkg::in_item_t it;
    it.mode = m;
    it.key_or_sample_time = t;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    return it;
  endfunction

  function automatic kvs_pkg::out_item_t make_res(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [1:0] s);
    kvs_pkg::out_item_t r;
    r.out_x = x;
    r.out_y = y;
    r.out_z = z;
    r.status = s;
    return r;
  endfunction

  typedef struct {
    kvs_pkg::in_item_t  item;
    bit                 has_golden;
    kvs_pkg::out_item_t golden;
  } row_t;

  row_t directed[$];

  task automatic add_row(kvs_pkg::in_item_t item, bit has_golden,
                         kvs_pkg::out_item_t golden);
    row_t r;
    r.item = item;
    r.has_golden = has_golden;
    r.golden = golden;
    directed.insert(directed.size(), r);
  endtask

  initial begin
    logic [31:0] t_acc;
    int n_keys;
    int roll;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    error_count = 0;
    idle_pct = 35;
    quiet_cycles = 0;
    key_count = 0;

    // Directed rows: empty sample, extremes, the unused mode and a clear.
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'h0, 0, 0, 0), 1,
            make_res(0, 0, 0, kvs_pkg::ST_EMPTY));
    add_row(make_item(kvs_pkg::MODE_APPEND, 32'h0001_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h0), 1, make_res(0, 0, 0, kvs_pkg::ST_OK));
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0), 1,
            make_res(32'h8000_0000, 32'h7FFF_FFFF, 0, kvs_pkg::ST_OK));
    add_row(make_item(kvs_pkg::MODE_APPEND, 32'h0003_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'hFFFF_FFFF), 1, make_res(0, 0, 0, kvs_pkg::ST_OK));
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'h0, 0, 0, 0), 1,
            make_res(32'h8000_0000, 32'h7FFF_FFFF, 0, kvs_pkg::ST_OK));
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'h0002_0000, 0, 0, 0), 0, '0);
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'h0003_0000, 0, 0, 0), 0, '0);
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'h0002_8001, 0, 0, 0), 0, '0);
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0), 1,
            make_res(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, kvs_pkg::ST_OK));
    // Equal times give a zero fraction; an unsorted key follows.
    add_row(make_item(kvs_pkg::MODE_APPEND, 32'h0003_0000, 32'h1234,
                      32'h5678, 32'h9ABC), 0, '0);
    add_row(make_item(kvs_pkg::MODE_APPEND, 32'h0000_8000, 32'h10000,
                      32'h20000, 32'h30000), 0, '0);
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'h0003_0000, 0, 0, 0), 0, '0);
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'h0003_0001, 0, 0, 0), 0, '0);
    add_row(make_item(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, make_res(0, 0, 0, kvs_pkg::ST_OK));
    add_row(make_item(kvs_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 0, 0, 0), 1,
            make_res(0, 0, 0, kvs_pkg::ST_OK));
    add_row(make_item(kvs_pkg::MODE_SAMPLE, 32'h5, 0, 0, 0), 1,
            make_res(0, 0, 0, kvs_pkg::ST_EMPTY));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].item, directed[i].has_golden,
                                    directed[i].golden);

    // Fill the table to the top, then overflow it.
    for (int k = 0; k < kvs_pkg::MAX_KEYS; k++)
      send_item(make_item(kvs_pkg::MODE_APPEND, 32'(k) << 12, $urandom, $urandom,
                          $urandom), 0, '0);
    send_item(make_item(kvs_pkg::MODE_APPEND, 32'h1, 1, 1, 1), 1,
              make_res(0, 0, 0, kvs_pkg::ST_FULL));
    send_item(make_item(kvs_pkg::MODE_SAMPLE, 32'h0003_F000, 0, 0, 0), 0, '0);

    // Random part: mostly clear, mostly sorted appends, then samples.
    for (int n = 0; n < N_RANDOM; ) begin
      idle_pct = (n > 400 && n < 600) ? 0 : 35;
      roll = $urandom_range(99);
      if (roll < 80) begin
        send_item(make_item(kvs_pkg::MODE_CLEAR, $urandom, $urandom, $urandom,
                            $urandom), 0, '0);
        n_keys = ($urandom_range(9) == 0) ? $urandom_range(kvs_pkg::MAX_KEYS) :
                                            $urandom_range(6);
        t_acc = $urandom_range(3) == 0 ? $urandom : $urandom_range(65535);
        for (int k = 0; k < n_keys; k++) begin
          send_item(make_item(kvs_pkg::MODE_APPEND, t_acc, $urandom, $urandom,
                              $urandom), 0, '0);
          if ($urandom_range(7) == 0) t_acc = $urandom;
          else if ($urandom_range(5) != 0) t_acc = t_acc + $urandom_range(32'h0002_0000);
        end
        n = n + 1 + n_keys;
        for (int s = $urandom_range(1, 5); s > 0; s--) begin
          if ($urandom_range(3) == 0) t_acc = $urandom;
          else t_acc = t_acc - $urandom_range(32'h0004_0000);
          send_item(make_item(kvs_pkg::MODE_SAMPLE, t_acc, $urandom, $urandom,
                              $urandom), 0, '0);
          n++;
        end
      end else begin
        send_item(make_item(2'($urandom), $urandom, $urandom, $urandom, $urandom),
                  0, '0);
        n++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray results.
    while (expected_vectors.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_vectors.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/kvs_pkg.sv
hdl/kvs_datapath.sv
hdl/kvs_ctrl.sv
hdl/keyframe_vector_sampler.sv
test/keyframe_vector_sampler_tb.sv
